### hdl/arrb_pkg.sv
// Shared types and constants for the acknowledged record ring buffer.
package arrb_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned INDEX_W   = 32;
  localparam int unsigned SECONDS_W = 32;
  localparam int unsigned MILLIS_W  = 10;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned PENDING_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FETCH   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONFIRM = 2'd2;

  // only bit 0 of the send status is ever reported
  localparam logic STATUS_NEW    = 1'b0;
  localparam logic STATUS_HANDED = 1'b1;

  typedef struct packed {
    logic [INDEX_W-1:0]   index;
    logic [SECONDS_W-1:0] seconds;
    logic [MILLIS_W-1:0]  millis;
    logic [WORD_W-1:0]    word0;
    logic [WORD_W-1:0]    word1;
    logic [WORD_W-1:0]    word2;
    logic [WORD_W-1:0]    word3;
  } rec_t;

  typedef struct packed {
    logic capture;  // latch the input item
    logic execute;  // commit the operation and load the result register
  } cmd_t;

endpackage

### hdl/arrb_ctrl.sv
// Controller state machine: input acceptance, execute step, result valid.
module arrb_ctrl import arrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // the result register must be free or emptied in this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/arrb_dp.sv
// Datapath: record and status memories, ring pointers, pending count, result register.
module arrb_dp import arrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [FUNC_W-1:0]     func_i,
  input  rec_t                  rec_i,
  output logic [PENDING_W-1:0]  pending_o,
  output logic                  fetch_valid_o,
  output logic                  confirm_ok_o,
  output rec_t                  rec_o,
  output logic                  status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  rec_t rec_mem  [DEPTH];
  logic stat_mem [DEPTH];
  rec_t rd_rec_q;
  logic rd_stat_q;

  // captured input item
  logic [FUNC_W-1:0] func_q;
  rec_t              item_q;

  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] sp_q, sp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          rec_we;
  logic          stat_we;
  logic [AW-1:0] stat_addr;
  logic          stat_wdata;
  logic          fetch_hit;
  logic          confirm_hit;
  logic          full;
  logic          nonempty;
  logic [31:0]   cnt_ext;

  assign full     = (cnt_q == CW'(DEPTH));
  assign nonempty = (cnt_q != '0);

  always_comb begin
    wp_d        = wp_q;
    sp_d        = sp_q;
    cnt_d       = cnt_q;
    rec_we      = 1'b0;
    stat_we     = 1'b0;
    stat_addr   = sp_q;
    stat_wdata  = STATUS_HANDED;
    fetch_hit   = 1'b0;
    confirm_hit = 1'b0;
    if (cmd_i.execute) begin
      case (func_q)
        FUNC_ADD: begin
          // a full ring loses its oldest record first
          if (full) begin
            sp_d = next_slot(sp_q);
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          rec_we     = 1'b1;
          stat_we    = 1'b1;
          stat_addr  = wp_q;
          stat_wdata = STATUS_NEW;
          wp_d       = next_slot(wp_q);
        end
        FUNC_FETCH: begin
          if (nonempty) begin
            fetch_hit = 1'b1;
            stat_we   = 1'b1;
          end
        end
        FUNC_CONFIRM: begin
          if (nonempty && (item_q.index == rd_rec_q.index)) begin
            confirm_hit = 1'b1;
            sp_d        = next_slot(sp_q);
            cnt_d       = cnt_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = 32'(cnt_d);

  // memories: one write port, read at the send pointer every cycle
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[wp_q] <= item_q;
    end
    if (stat_we) begin
      stat_mem[stat_addr] <= stat_wdata;
    end
    rd_rec_q  <= rec_mem[sp_q];
    rd_stat_q <= stat_mem[sp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      item_q <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      sp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      sp_q  <= sp_d;
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      pending_o     <= cnt_ext[PENDING_W-1:0];
      fetch_valid_o <= fetch_hit;
      confirm_ok_o  <= confirm_hit;
      rec_o         <= fetch_hit ? rd_rec_q : '0;
      status_o      <= fetch_hit ? rd_stat_q : 1'b0;
    end
  end

endmodule

### hdl/acked_record_ring_buffer.sv
// Top level of the acknowledged record ring buffer.
//
// Input channel (in_valid_i / in_ready_o) carries one operation: add a
// record, fetch the oldest pending record, or confirm it by index. Every
// operation returns exactly one result on the output channel
// (out_valid_o / out_ready_i) with the pending count after the operation.
// Each operation is first transferred, then executed in a step that uses
// the record memory's registered read at the send pointer. The result is
// valid in the cycle after execute; a new operation is accepted only once
// the previous one has executed. The result register lets the
// next input transfer happen while a result still waits; if the receiver
// stalls, the execute step holds until the result register is taken.
// Reset clears the pointers and the pending count; record contents are
// not cleared and are only read once written. Fields of a result that is
// not a successful fetch read as zero.
module acked_record_ring_buffer import arrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [INDEX_W-1:0]   rec_index_i,
  input  logic [SECONDS_W-1:0] time_seconds_i,
  input  logic [MILLIS_W-1:0]  time_millis_i,
  input  logic [WORD_W-1:0]    sensor_word0_i,
  input  logic [WORD_W-1:0]    sensor_word1_i,
  input  logic [WORD_W-1:0]    sensor_word2_i,
  input  logic [WORD_W-1:0]    sensor_word3_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PENDING_W-1:0] pending_out_o,
  output logic                 fetch_valid_o,
  output logic                 confirm_ok_o,
  output logic [INDEX_W-1:0]   out_index_o,
  output logic [SECONDS_W-1:0] out_seconds_o,
  output logic [MILLIS_W-1:0]  out_millis_o,
  output logic [WORD_W-1:0]    out_word0_o,
  output logic [WORD_W-1:0]    out_word1_o,
  output logic [WORD_W-1:0]    out_word2_o,
  output logic [WORD_W-1:0]    out_word3_o,
  output logic                 out_status_o
);

  cmd_t cmd;
  rec_t in_rec;
  rec_t out_rec;

  assign in_rec.index   = rec_index_i;
  assign in_rec.seconds = time_seconds_i;
  assign in_rec.millis  = time_millis_i;
  assign in_rec.word0   = sensor_word0_i;
  assign in_rec.word1   = sensor_word1_i;
  assign in_rec.word2   = sensor_word2_i;
  assign in_rec.word3   = sensor_word3_i;

  arrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  arrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .rec_i         (in_rec),
    .pending_o     (pending_out_o),
    .fetch_valid_o (fetch_valid_o),
    .confirm_ok_o  (confirm_ok_o),
    .rec_o         (out_rec),
    .status_o      (out_status_o)
  );

  assign out_index_o   = out_rec.index;
  assign out_seconds_o = out_rec.seconds;
  assign out_millis_o  = out_rec.millis;
  assign out_word0_o   = out_rec.word0;
  assign out_word1_o   = out_rec.word1;
  assign out_word2_o   = out_rec.word2;
  assign out_word3_o   = out_rec.word3;

endmodule

### hdl/arrb_checker.sv
// Port-level checks for the acknowledged record ring buffer, bound to the top level.
module arrb_checker import arrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [PENDING_W-1:0] pending_out_o,
  input logic                 fetch_valid_o,
  input logic                 confirm_ok_o,
  input logic [INDEX_W-1:0]   out_index_o,
  input logic                 out_status_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pending_out_o) && $stable(fetch_valid_o)
      && $stable(confirm_ok_o) && $stable(out_index_o))
    else $error("result changed while stalled");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fetch_valid_o && confirm_ok_o))
    else $error("fetch and confirm flags both set");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fetch_valid_o |-> (out_index_o == '0) && !out_status_o)
    else $error("record fields not zero outside a fetch");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(pending_out_o) <= DEPTH))
    else $error("pending count above ring depth");

  // one transfer in flight: no new input right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an operation is in progress");

endmodule

bind acked_record_ring_buffer arrb_checker #(.DEPTH(DEPTH)) u_arrb_checker (.*);
